### design/fgns_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the fractal gradient noise sampler.
// No dependencies; fgns_if, fgns_gen and the top level use it.
package fgns_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int COORD_BITS_DEF  = 12;
  localparam int MAX_OCTAVES_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_LOG2,
    CFG_GRID_WIDTH,
    CFG_GRID_HEIGHT,
    CFG_OCTAVE_COUNT,
    CFG_PERSISTENCE,
    CFG_WRAP_MODE,
    CFG_SEED
  } cfg_idx_t;

  localparam logic [3:0]  SCALE_RESET   = 4'd6;
  localparam logic [6:0]  GRID_RESET    = 7'd8;
  localparam logic [3:0]  OCTAVE_RESET  = 4'd3;
  localparam logic [3:0]  PERSIST_RESET = 4'd3;
  localparam logic [1:0]  WRAP_RESET    = 2'd3;
  localparam logic [23:0] SEED_RESET    = 24'd7665074;

  // LCG multiplier 5265881563 split as KHI * 2^17 + KLO
  localparam logic [16:0] GEN_KLO = 17'd63963;
  localparam logic [15:0] GEN_KHI = 16'd40175;
  localparam logic [23:0] GEN_ADD = 24'd14702291;

  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [30:0] PC1 = 31'd1686629713;
  localparam logic [30:0] PC3 = 31'd693598668;
  localparam logic [30:0] PC5 = 31'd85569306;
  localparam logic [30:0] PC7 = 31'd5026996;
  localparam logic [30:0] PC9 = 31'd172272;

  localparam logic [16:0] INV_SQRT2_Q16 = 17'd46341;

  // weighted sum and weight sum for up to eight octaves of base 15
  localparam int NUM_W = 45;
  localparam int DEN_W = 28;

  typedef struct packed {
    logic        start;
    logic        load;
    logic [23:0] seed;
  } gen_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] word;
  } gen_rsp_t;

endpackage

### design/fgns_if.sv
`timescale 1ns / 1ps
// Request and result channels of the fractal gradient noise sampler.
// Depends on fgns_pkg for default widths.
interface fgns_in_if #(
  parameter int COORD_BITS = fgns_pkg::COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface fgns_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] noise_value;
  logic        table_overflow;

  modport source (output valid, noise_value, table_overflow, input ready);
  modport sink   (input valid, noise_value, table_overflow, output ready);
endinterface

### design/fractal_gradient_noise_sampler.sv
`timescale 1ns / 1ps
// Fractal gradient noise sampler, top level: gradient table, sequencer, config.
// Depends on fgns_pkg, fgns_if, fgns_div and fgns_gen.
//
//   channel   direction  handshake        payload
//   in_ch     in         valid / ready    pixel_x, pixel_y
//   out_ch    out        valid / ready    noise_value, table_overflow
//   cfg_*     in         cfg_we           cfg_index, cfg_data
//
// One request at a time. Key pass per octave: the modulo units reduce the
// coordinates, then the four corner keys are formed. Sample pass per octave:
// a table read per corner, and a gradient generated on a miss (shared sine
// multiplier). A final weighting division follows the last octave.
// After reset the table valid bits are cleared, one entry per cycle, with
// in_ch.ready low. A finished result waits in the output register while the
// next request is taken.
module fractal_gradient_noise_sampler #(
  parameter int TABLE_DEPTH = fgns_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = fgns_pkg::COORD_BITS_DEF,
  parameter int MAX_OCTAVES = fgns_pkg::MAX_OCTAVES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fgns_in_if.sink                          in_ch,
  fgns_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [fgns_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fgns_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fgns_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int OW = $clog2(MAX_OCTAVES + 1);
  localparam int IW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int EW = 7 + MAX_OCTAVES;
  localparam int VW = (COORD_BITS + 1 > EW) ? COORD_BITS + 1 : EW;
  localparam int KW = 2 * VW + 4;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_P1_START, S_P1_MOD, S_P1_KEY, S_P1_BASE,
    S_FADE1, S_FADE2, S_FADE3, S_RD, S_CHK, S_GEN, S_DOT, S_DSUM,
    S_L1, S_L2, S_L3, S_L4, S_N1, S_N2, S_ACC, S_DIV, S_DIVW, S_OUT
  } state_t;

  // configuration
  logic [3:0] scale_log2_r;
  logic [6:0] grid_width_r;
  logic [6:0] grid_height_r;
  logic [3:0] octave_count_r;
  logic [3:0] persistence_r;
  logic [1:0] wrap_mode_r;

  state_t                state_r;
  logic [AW-1:0]         clr_addr_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic [OW-1:0]         n_r;
  logic [3:0]            pers_r;
  logic [OW-1:0]         i_r;
  logic [1:0]            j_r;
  logic                  over_r;
  logic [KW-1:0]         base_r;
  logic [VW-1:0]         cx_r, cy_r;
  logic [AW-1:0]         keys_r [MAX_OCTAVES][4];
  logic [31:0]           t2x_r, t2y_r, t3x_r, t3y_r;
  logic [19:0]           innx_r, inny_r;
  logic [16:0]           fx_r, fy_r;
  logic [31:0]           gword_r;
  logic signed [33:0]    pc_r, ps_r;
  logic signed [34:0]    d_r [4];
  logic signed [55:0]    m0_r, m1_r;
  logic signed [36:0]    e0_r, e1_r, nv_r;
  logic [16:0]           u_r;
  logic [NUM_W-1:0]      num_r;
  logic [DEN_W-1:0]      den_r;
  logic [15:0]           res_val_r;
  logic                  res_ovf_r;
  logic                  out_valid_r;
  logic [15:0]           out_val_r;
  logic                  out_ovf_r;

  // gradient table: valid bit on top of the packed (sin, cos) word
  logic [32:0]   mem [TABLE_DEPTH];
  logic [32:0]   rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [32:0]   mem_wd;
  logic [AW-1:0] rd_addr;

  // per-octave geometry
  logic [6:0]            gw_e, gh_e;
  logic                  wx, wy;
  logic [3:0]            s_cur;
  logic [COORD_BITS-1:0] xs, ys;
  logic [EW-1:0]         w_x, h_y, rx, ry;
  logic [COORD_BITS+15:0] txw, tyw;
  logic [15:0]           tx, ty;

  // key pass
  logic [VW-1:0]     vx_raw, vy_raw, vx, vy;
  logic [VW+EW-1:0]  vyrx;
  logic [KW-1:0]     key;
  logic              key_ov;
  logic [2*EW-1:0]   area;

  // fade
  logic [47:0] f3x, f3y;
  logic [37:0] inwx, inwy;
  logic [52:0] fsx, fsy;

  // dot and blend
  logic signed [15:0] gc, gs;
  logic signed [17:0] dx, dy;
  logic signed [35:0] diff0, diff1;
  logic signed [37:0] diff2;
  logic signed [17:0] fxs, fys;
  logic signed [55:0] rs0, rs1;
  logic signed [55:0] rsn;
  logic signed [26:0] uu;

  // weighting
  logic [NUM_W+3:0] num_mul;
  logic [DEN_W+3:0] den_mul;
  logic [NUM_W-1:0] dividend;

  gen_req_t gen_req;
  gen_rsp_t gen_rsp;

  logic                  mod_start, mod_done, mod_done_y;
  logic [COORD_BITS-1:0] modq_x, modq_y;
  logic [EW-1:0]         modr_x, modr_y;
  logic                  div_start, div_done;
  logic [NUM_W-1:0]      div_q;
  logic [DEN_W-1:0]      div_r;

  logic last_oct;
  logic in_fire;

  assign gw_e  = (grid_width_r == '0)  ? 7'd1 : grid_width_r;
  assign gh_e  = (grid_height_r == '0) ? 7'd1 : grid_height_r;
  assign wx    = wrap_mode_r[0];
  assign wy    = wrap_mode_r[1];
  assign s_cur = ({1'b0, scale_log2_r} >= 5'(i_r)) ? scale_log2_r - 4'(i_r) : 4'd0;
  assign xs    = x_r >> s_cur;
  assign ys    = y_r >> s_cur;
  assign w_x   = EW'(gw_e) << i_r;
  assign h_y   = EW'(gh_e) << i_r;
  assign rx    = wx ? w_x : w_x + 1'b1;
  assign ry    = wy ? h_y : h_y + 1'b1;
  assign txw   = {x_r, 16'b0} >> s_cur;
  assign tyw   = {y_r, 16'b0} >> s_cur;
  assign tx    = txw[15:0];
  assign ty    = tyw[15:0];
  assign last_oct = (i_r == n_r - 1'b1);

  // corner indices, wrapped per axis
  assign vx_raw = cx_r + VW'(j_r[0]);
  assign vy_raw = cy_r + VW'(j_r[1]);
  assign vx     = (wx && vx_raw == VW'(w_x)) ? '0 : vx_raw;
  assign vy     = (wy && vy_raw == VW'(h_y)) ? '0 : vy_raw;
  assign vyrx   = vy * rx;
  assign key    = base_r + KW'(vyrx) + KW'(vx);
  assign key_ov = (vx >= VW'(rx)) || (vy >= VW'(ry)) || (key >= KW'(TABLE_DEPTH));
  assign area   = rx * ry;

  assign f3x  = t2x_r * tx;
  assign f3y  = t2y_r * ty;
  assign inwx = (38'd10 << 32) - ((38'(tx) * 38'd15) << 16) + 38'(t2x_r) * 38'd6;
  assign inwy = (38'd10 << 32) - ((38'(ty) * 38'd15) << 16) + 38'(t2y_r) * 38'd6;
  assign fsx  = t3x_r * innx_r + 53'd2147483648;
  assign fsy  = t3y_r * inny_r + 53'd2147483648;

  assign gc    = $signed(gword_r[15:0]);
  assign gs    = $signed(gword_r[31:16]);
  assign dx    = $signed({2'b00, tx}) - (j_r[0] ? 18'sd65536 : 18'sd0);
  assign dy    = $signed({2'b00, ty}) - (j_r[1] ? 18'sd65536 : 18'sd0);
  assign diff0 = d_r[1] - d_r[0];
  assign diff1 = d_r[3] - d_r[2];
  assign diff2 = e1_r - e0_r;
  assign fxs   = $signed({1'b0, fx_r});
  assign fys   = $signed({1'b0, fy_r});
  assign rs0   = (m0_r + 56'sd32768) >>> 16;
  assign rs1   = (m1_r + 56'sd32768) >>> 16;
  assign rsn   = (m0_r + 56'sd536870912) >>> 30;
  assign uu    = 27'sd32768 + $signed(rsn[26:0]);

  assign num_mul  = num_r * pers_r;
  assign den_mul  = den_r * pers_r;
  assign dividend = num_r + NUM_W'(den_r >> 1);

  assign rd_addr = keys_r[i_r[IW-1:0]][j_r];
  assign mem_we  = (state_r == S_CLEAR) || (state_r == S_GEN && gen_rsp.done);
  assign mem_wa  = (state_r == S_CLEAR) ? clr_addr_r : rd_addr;
  assign mem_wd  = (state_r == S_CLEAR) ? 33'd0 : {1'b1, gen_rsp.word};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[rd_addr];
  end

  assign gen_req.start = (state_r == S_CHK) && !rdata_r[32];
  assign gen_req.load  = cfg_we && (cfg_idx_t'(cfg_index) == CFG_SEED);
  assign gen_req.seed  = cfg_data[23:0];

  fgns_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (gen_req),
    .rsp   (gen_rsp)
  );

  assign mod_start = (state_r == S_P1_START);
  assign div_start = (state_r == S_DIV);

  fgns_div #(.NW(COORD_BITS), .DW(EW)) u_mod_x (
    .clk (clk), .rst_n (rst_n), .start (mod_start), .dividend (xs), .divisor (w_x),
    .done (mod_done), .quotient (modq_x), .remainder (modr_x)
  );

  fgns_div #(.NW(COORD_BITS), .DW(EW)) u_mod_y (
    .clk (clk), .rst_n (rst_n), .start (mod_start), .dividend (ys), .divisor (h_y),
    .done (mod_done_y), .quotient (modq_y), .remainder (modr_y)
  );

  fgns_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk (clk), .rst_n (rst_n), .start (div_start), .dividend (dividend),
    .divisor (den_r), .done (div_done), .quotient (div_q), .remainder (div_r)
  );

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.noise_value    = out_val_r;
  assign out_ch.table_overflow = out_ovf_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_log2_r   <= SCALE_RESET;
      grid_width_r   <= GRID_RESET;
      grid_height_r  <= GRID_RESET;
      octave_count_r <= OCTAVE_RESET;
      persistence_r  <= PERSIST_RESET;
      wrap_mode_r    <= WRAP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCALE_LOG2:   scale_log2_r   <= cfg_data[3:0];
        CFG_GRID_WIDTH:   grid_width_r   <= cfg_data[6:0];
        CFG_GRID_HEIGHT:  grid_height_r  <= cfg_data[6:0];
        CFG_OCTAVE_COUNT: octave_count_r <= cfg_data[3:0];
        CFG_PERSISTENCE:  persistence_r  <= cfg_data[3:0];
        CFG_WRAP_MODE:    wrap_mode_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      over_r      <= 1'b0;
    end else begin
      // S_OUT reloads the register itself
      if (out_ch.valid && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(TABLE_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            x_r    <= in_ch.pixel_x;
            y_r    <= in_ch.pixel_y;
            if (octave_count_r == '0) begin
              n_r <= OW'(1);
            end else if (octave_count_r > 4'(MAX_OCTAVES)) begin
              n_r <= OW'(MAX_OCTAVES);
            end else begin
              n_r <= OW'(octave_count_r);
            end
            pers_r  <= (persistence_r == '0) ? 4'd1 : persistence_r;
            i_r     <= '0;
            over_r  <= 1'b0;
            base_r  <= '0;
            num_r   <= '0;
            den_r   <= '0;
            state_r <= S_P1_START;
          end
        end
        S_P1_START: state_r <= S_P1_MOD;
        S_P1_MOD: begin
          if (mod_done) begin
            cx_r    <= wx ? VW'(modr_x) : VW'(xs);
            cy_r    <= wy ? VW'(modr_y) : VW'(ys);
            j_r     <= '0;
            state_r <= S_P1_KEY;
          end
        end
        S_P1_KEY: begin
          keys_r[i_r[IW-1:0]][j_r] <= key[AW-1:0];
          if (key_ov) begin
            over_r <= 1'b1;
          end
          j_r <= j_r + 1'b1;
          if (j_r == 2'd3) begin
            state_r <= S_P1_BASE;
          end
        end
        S_P1_BASE: begin
          base_r <= base_r + KW'(area);
          if (!last_oct) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_P1_START;
          end else if (over_r) begin
            res_val_r <= '0;
            res_ovf_r <= 1'b1;
            state_r   <= S_OUT;
          end else begin
            i_r     <= '0;
            state_r <= S_FADE1;
          end
        end
        S_FADE1: begin
          t2x_r   <= tx * tx;
          t2y_r   <= ty * ty;
          state_r <= S_FADE2;
        end
        S_FADE2: begin
          t3x_r   <= f3x[47:16];
          t3y_r   <= f3y[47:16];
          innx_r  <= inwx[35:16];
          inny_r  <= inwy[35:16];
          state_r <= S_FADE3;
        end
        S_FADE3: begin
          fx_r    <= fsx[48:32];
          fy_r    <= fsy[48:32];
          j_r     <= '0;
          state_r <= S_RD;
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (rdata_r[32]) begin
            gword_r <= rdata_r[31:0];
            state_r <= S_DOT;
          end else begin
            state_r <= S_GEN;
          end
        end
        S_GEN: begin
          if (gen_rsp.done) begin
            gword_r <= gen_rsp.word;
            state_r <= S_DOT;
          end
        end
        S_DOT: begin
          pc_r    <= gc * dx;
          ps_r    <= gs * dy;
          state_r <= S_DSUM;
        end
        S_DSUM: begin
          d_r[j_r] <= pc_r + ps_r;
          j_r      <= j_r + 1'b1;
          state_r  <= (j_r == 2'd3) ? S_L1 : S_RD;
        end
        S_L1: begin
          m0_r    <= diff0 * fxs;
          m1_r    <= diff1 * fxs;
          state_r <= S_L2;
        end
        S_L2: begin
          e0_r    <= d_r[0] + $signed(rs0[36:0]);
          e1_r    <= d_r[2] + $signed(rs1[36:0]);
          state_r <= S_L3;
        end
        S_L3: begin
          m0_r    <= diff2 * fys;
          state_r <= S_L4;
        end
        S_L4: begin
          nv_r    <= e0_r + $signed(rs0[36:0]);
          state_r <= S_N1;
        end
        S_N1: begin
          m0_r    <= nv_r * $signed({1'b0, INV_SQRT2_Q16});
          state_r <= S_N2;
        end
        S_N2: begin
          if (uu < 0) begin
            u_r <= '0;
          end else if (uu > 27'sd65536) begin
            u_r <= 17'd65536;
          end else begin
            u_r <= uu[16:0];
          end
          state_r <= S_ACC;
        end
        S_ACC: begin
          // Horner form gives octave i the weight persistence^(n-1-i)
          num_r <= NUM_W'(num_mul) + NUM_W'(u_r);
          den_r <= DEN_W'(den_mul) + 1'b1;
          if (last_oct) begin
            state_r <= S_DIV;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_FADE1;
          end
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            res_val_r <= (div_q > NUM_W'(65535)) ? 16'hFFFF : div_q[15:0];
            res_ovf_r <= 1'b0;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_val_r   <= res_val_r;
            out_ovf_r   <= res_ovf_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### design/fgns_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module fgns_div #(
  parameter int NW = 16,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          take;

  assign trial = {rem_r, quo_r[NW-1]};
  assign take  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= take ? DW'(trial - {1'b0, dsr_r}) : trial[DW-1:0];
        quo_r <= {quo_r[NW-2:0], take};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule

### design/fgns_gen.sv
`timescale 1ns / 1ps
// Gradient generator: fractional LCG step, then cos and sin by a shared
// 31x31 polynomial multiplier. Depends on fgns_pkg.
module fgns_gen (
  input  logic               clk,
  input  logic               rst_n,
  input  fgns_pkg::gen_req_t req,
  output fgns_pkg::gen_rsp_t rsp
);
  import fgns_pkg::*;

  typedef enum logic [2:0] {G_IDLE, G_LO, G_HI, G_SUM, G_POLY} gstate_t;

  gstate_t     state_r;
  logic [23:0] g_r;
  logic [40:0] plo_r;
  logic [39:0] phi_r;
  logic [29:0] u_r;
  logic [30:0] arg_r;
  logic [30:0] u2_r;
  logic [30:0] pp_r;
  logic [2:0]  step_r;
  logic        pass_r;
  logic [14:0] sv_r;
  logic [1:0]  quad_r;
  logic        done_r;
  logic [31:0] word_r;

  logic [47:0] sum48;
  logic [30:0] ma, mb;
  logic [61:0] prod;
  logic [31:0] sh;
  logic [30:0] coef;
  logic [31:0] vcl;
  logic [31:0] vrnd;
  logic [14:0] q14;
  logic [15:0] cpos, spos, cneg, sneg;
  logic [15:0] cval, sval;

  assign sum48 = 48'(plo_r) + {phi_r[30:0], 17'b0} + {GEN_ADD, 24'b0};

  always_comb begin
    ma = (step_r == 3'd0 || step_r == 3'd5) ? arg_r : u2_r;
    case (step_r)
      3'd0:    mb = arg_r;
      3'd1:    mb = PC9;
      default: mb = pp_r;
    endcase
    case (step_r)
      3'd1:    coef = PC7;
      3'd2:    coef = PC5;
      3'd3:    coef = PC3;
      default: coef = PC1;
    endcase
  end

  assign prod = ma * mb;
  assign sh   = prod[61:30];
  assign vcl  = (sh > 32'(ONE_Q30)) ? 32'(ONE_Q30) : sh;
  assign vrnd = vcl + 32'd32768;
  assign q14  = vrnd[30:16];

  // second pass yields cos; sin was kept from the first
  assign cpos = {1'b0, q14};
  assign spos = {1'b0, sv_r};
  assign cneg = 16'd0 - cpos;
  assign sneg = 16'd0 - spos;

  always_comb begin
    case (quad_r)
      2'd0:    begin cval = cpos; sval = spos; end
      2'd1:    begin cval = sneg; sval = cpos; end
      2'd2:    begin cval = cneg; sval = sneg; end
      default: begin cval = spos; sval = cneg; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      g_r     <= SEED_RESET;
      done_r  <= 1'b0;
      step_r  <= '0;
      pass_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        G_IDLE: begin
          if (req.load) begin
            g_r <= req.seed;
          end else if (req.start) begin
            state_r <= G_LO;
          end
        end
        G_LO: begin
          plo_r   <= g_r * GEN_KLO;
          state_r <= G_HI;
        end
        G_HI: begin
          phi_r   <= g_r * GEN_KHI;
          state_r <= G_SUM;
        end
        G_SUM: begin
          g_r     <= sum48[47:24];
          quad_r  <= sum48[47:46];
          u_r     <= {sum48[45:24], 8'b0};
          arg_r   <= {1'b0, sum48[45:24], 8'b0};
          step_r  <= '0;
          pass_r  <= 1'b0;
          state_r <= G_POLY;
        end
        G_POLY: begin
          case (step_r)
            3'd0: begin
              u2_r   <= sh[30:0];
              step_r <= 3'd1;
            end
            3'd5: begin
              step_r <= '0;
              if (!pass_r) begin
                sv_r   <= q14;
                arg_r  <= ONE_Q30 - {1'b0, u_r};
                pass_r <= 1'b1;
              end else begin
                word_r  <= {sval, cval};
                done_r  <= 1'b1;
                state_r <= G_IDLE;
              end
            end
            default: begin
              pp_r   <= coef - sh[30:0];
              step_r <= step_r + 3'd1;
            end
          endcase
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.word = word_r;
endmodule
